// ----- hdl/eep_pkg.sv -----
// Shared types and constants for the internal EEPROM port controller.
package eep_pkg;

  localparam int unsigned SEL_ADDR_W  = 10;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic       OP_READ  = 1'b0;
  localparam logic       OP_WRITE = 1'b1;

  localparam logic [2:0] SEL_DATA_LO = 3'd0;
  localparam logic [2:0] SEL_DATA_HI = 3'd1;
  localparam logic [2:0] SEL_ADDR_LO = 3'd2;
  localparam logic [2:0] SEL_ADDR_HI = 3'd3;
  localparam logic [2:0] SEL_CMD     = 3'd4;

  localparam int unsigned CMD_SUB_BIT   = 6;
  localparam int unsigned CMD_WRITE_BIT = 5;
  localparam int unsigned CMD_READ_BIT  = 4;

  localparam logic [1:0] SUB_WRITE_DISABLE = 2'd0;
  localparam logic [1:0] SUB_WRITE_ALL     = 2'd1;
  localparam logic [1:0] SUB_ERASE_ALL     = 2'd2;
  localparam logic [1:0] SUB_WRITE_ENABLE  = 2'd3;

  localparam logic [1:0] OPCODE_EXTENDED = 2'd0;

  localparam logic [7:0] ACK_WRITE = 8'h02;
  localparam logic [7:0] ACK_READ  = 8'h01;
  localparam logic [7:0] ACK_IDLE  = 8'h03;

  typedef enum logic [2:0] {
    KIND_RD_DATA,
    KIND_WR_DATA,
    KIND_RD_ADDR,
    KIND_WR_ADDR,
    KIND_RD_STATUS,
    KIND_WR_CMD,
    KIND_RD_ZERO,
    KIND_WR_NONE
  } item_kind_e;

  typedef struct packed {
    item_kind_e kind;
    logic       hi;
    logic [7:0] wdata;
  } queue_entry_t;

  typedef struct packed {
    logic         valid;
    queue_entry_t entry;
  } queue_head_t;

endpackage

// ----- hdl/eep_req_if.sv -----
// Request channel carrying one bus access per transfer.
interface eep_req_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [2:0] reg_sel;
  logic [7:0] wdata;

  modport source (output valid, output op, output reg_sel, output wdata, input ready);
  modport sink (input valid, input op, input reg_sel, input wdata, output ready);
endinterface

// ----- hdl/eep_rsp_if.sv -----
// Response channel carrying one read data byte per transfer.
interface eep_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] rdata;

  modport source (output valid, output rdata, input ready);
  modport sink (input valid, input rdata, output ready);
endinterface

// ----- hdl/eep_ram.sv -----
// Generic single-port RAM with registered read data.
module eep_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ----- hdl/eep_front.sv -----
// Front end that accepts bus accesses, classifies them and queues them.
module eep_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  eep_req_if.sink            req_i,
  input  logic               pop_i,
  output eep_pkg::queue_head_t head_o
);

  eep_pkg::queue_entry_t             entries_q [eep_pkg::QUEUE_DEPTH];
  eep_pkg::queue_entry_t             class_d;
  logic [eep_pkg::QPTR_W-1:0]        wr_ptr_q;
  logic [eep_pkg::QPTR_W-1:0]        rd_ptr_q;
  logic [eep_pkg::QCNT_W-1:0]        count_q;
  logic                              push;

  assign req_i.ready = (count_q != eep_pkg::QCNT_W'(eep_pkg::QUEUE_DEPTH));
  assign push        = req_i.valid && req_i.ready;

  always_comb begin
    class_d.wdata = req_i.wdata;
    class_d.hi    = (req_i.reg_sel == eep_pkg::SEL_DATA_HI) ||
                    (req_i.reg_sel == eep_pkg::SEL_ADDR_HI);
    unique case (req_i.reg_sel)
      eep_pkg::SEL_DATA_LO, eep_pkg::SEL_DATA_HI: begin
        class_d.kind = (req_i.op == eep_pkg::OP_WRITE) ? eep_pkg::KIND_WR_DATA
                                                       : eep_pkg::KIND_RD_DATA;
      end
      eep_pkg::SEL_ADDR_LO, eep_pkg::SEL_ADDR_HI: begin
        class_d.kind = (req_i.op == eep_pkg::OP_WRITE) ? eep_pkg::KIND_WR_ADDR
                                                       : eep_pkg::KIND_RD_ADDR;
      end
      eep_pkg::SEL_CMD: begin
        class_d.kind = (req_i.op == eep_pkg::OP_WRITE) ? eep_pkg::KIND_WR_CMD
                                                       : eep_pkg::KIND_RD_STATUS;
      end
      default: begin
        class_d.kind = (req_i.op == eep_pkg::OP_WRITE) ? eep_pkg::KIND_WR_NONE
                                                       : eep_pkg::KIND_RD_ZERO;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= class_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == eep_pkg::QPTR_W'(eep_pkg::QUEUE_DEPTH - 1)) ? '0
                    : wr_ptr_q + eep_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == eep_pkg::QPTR_W'(eep_pkg::QUEUE_DEPTH - 1)) ? '0
                    : rd_ptr_q + eep_pkg::QPTR_W'(1);
      end
      if (push && !pop_i) begin
        count_q <= count_q + eep_pkg::QCNT_W'(1);
      end else if (!push && pop_i) begin
        count_q <= count_q - eep_pkg::QCNT_W'(1);
      end
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.entry = entries_q[rd_ptr_q];

endmodule

// ----- hdl/eep_back.sv -----
// Back end that executes queued accesses against the registers and the store.
module eep_back #(
  parameter int unsigned COLOR_STORE_BYTES = 1024,
  parameter int unsigned MONO_STORE_BYTES  = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  eep_pkg::queue_head_t head_i,
  output logic                 pop_o,
  eep_rsp_if.source            rsp_o
);

  localparam int unsigned STORE_DEPTH = (COLOR_STORE_BYTES > MONO_STORE_BYTES) ?
                                        COLOR_STORE_BYTES : MONO_STORE_BYTES;
  localparam int unsigned MIN_SIZE    = (COLOR_STORE_BYTES < MONO_STORE_BYTES) ?
                                        COLOR_STORE_BYTES : MONO_STORE_BYTES;
  localparam int unsigned AW          = $clog2(STORE_DEPTH);
  localparam int unsigned SW          = eep_pkg::SEL_ADDR_W;
  localparam int unsigned STEPS       = SW + 2 - $clog2(MIN_SIZE + 1);
  localparam int unsigned WW          = SW + 2 + STEPS;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_ERASE
  } state_e;

  function automatic logic [AW-1:0] wrap_index(input logic [SW:0] v, input int unsigned size);
    logic [WW-1:0] r;
    logic [WW-1:0] m;
    r = WW'(v);
    for (int k = STEPS - 1; k >= 0; k--) begin
      m = WW'(size) << k;
      if (r >= m) begin
        r = r - m;
      end
    end
    return r[AW-1:0];
  endfunction

  state_e                state_q;
  eep_pkg::queue_entry_t cur_q;
  logic [AW-1:0]         cnt_q;
  logic                  color_mode_q;
  logic                  wen_q;
  logic [SW-1:0]         sel_addr_q;
  logic [7:0]            addr_lo_q;
  logic [7:0]            addr_hi_q;
  logic [7:0]            cmd_q;
  logic                  out_valid_q;
  logic [7:0]            out_data_q;

  logic [SW:0]           sum;
  logic [AW-1:0]         idx;
  logic [AW-1:0]         erase_last;
  logic                  ram_we;
  logic [AW-1:0]         ram_addr;
  logic [7:0]            ram_wdata;
  logic [7:0]            ram_rdata;
  logic [15:0]           word;
  logic [1:0]            opcode;
  logic [1:0]            sub;
  logic [SW-1:0]         cmd_addr;
  logic [7:0]            status;
  logic                  exec_erase;
  logic [7:0]            exec_data;

  assign sum = {1'b0, sel_addr_q} + {{SW{1'b0}}, cur_q.hi};
  assign idx = color_mode_q ? wrap_index(sum, COLOR_STORE_BYTES)
                            : wrap_index(sum, MONO_STORE_BYTES);
  assign erase_last = color_mode_q ? AW'(COLOR_STORE_BYTES - 1) : AW'(MONO_STORE_BYTES - 1);

  assign word = {addr_hi_q, addr_lo_q};
  always_comb begin
    if (color_mode_q) begin
      opcode   = word[11:10];
      cmd_addr = word[9:0];
      sub      = word[9:8];
    end else begin
      opcode   = word[7:6];
      cmd_addr = {{(SW - 6){1'b0}}, word[5:0]};
      sub      = word[5:4];
    end
  end

  always_comb begin
    priority if (cmd_q[eep_pkg::CMD_WRITE_BIT]) begin
      status = cmd_q | eep_pkg::ACK_WRITE;
    end else if (cmd_q[eep_pkg::CMD_READ_BIT]) begin
      status = cmd_q | eep_pkg::ACK_READ;
    end else begin
      status = cmd_q | eep_pkg::ACK_IDLE;
    end
  end

  assign exec_erase = (cur_q.kind == eep_pkg::KIND_WR_CMD) &&
                      cur_q.wdata[eep_pkg::CMD_SUB_BIT] &&
                      (opcode == eep_pkg::OPCODE_EXTENDED) &&
                      (sub == eep_pkg::SUB_ERASE_ALL);

  always_comb begin
    unique case (cur_q.kind)
      eep_pkg::KIND_RD_ADDR:   exec_data = cur_q.hi ? addr_hi_q : addr_lo_q;
      eep_pkg::KIND_RD_STATUS: exec_data = status;
      default:                 exec_data = '0;
    endcase
  end

  always_comb begin
    if ((state_q == ST_CLEAR) || (state_q == ST_ERASE)) begin
      ram_we    = 1'b1;
      ram_addr  = cnt_q;
      ram_wdata = '0;
    end else begin
      ram_we    = (state_q == ST_EXEC) && (cur_q.kind == eep_pkg::KIND_WR_DATA) && wen_q;
      ram_addr  = idx;
      ram_wdata = cur_q.wdata;
    end
  end

  eep_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign pop_o       = (state_q == ST_IDLE) && head_i.valid && !out_valid_q;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.rdata = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      cur_q        <= '0;
      cnt_q        <= '0;
      color_mode_q <= 1'b0;
      wen_q        <= 1'b0;
      sel_addr_q   <= '0;
      addr_lo_q    <= '0;
      addr_hi_q    <= '0;
      cmd_q        <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        color_mode_q <= cfg_wdata_i;
      end
      if (rsp_o.valid && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          cnt_q <= cnt_q + AW'(1);
          if (cnt_q == AW'(STORE_DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (pop_o) begin
            cur_q   <= head_i.entry;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          out_valid_q <= (cur_q.kind != eep_pkg::KIND_RD_DATA);
          out_data_q  <= exec_data;
          if (cur_q.kind == eep_pkg::KIND_RD_DATA) begin
            state_q <= ST_READ;
          end else if (exec_erase) begin
            state_q <= ST_ERASE;
          end else begin
            state_q <= ST_IDLE;
          end
          unique case (cur_q.kind)
            eep_pkg::KIND_WR_ADDR: begin
              if (cur_q.hi) begin
                addr_hi_q <= cur_q.wdata;
              end else begin
                addr_lo_q <= cur_q.wdata;
              end
            end
            eep_pkg::KIND_WR_CMD: begin
              cmd_q <= cur_q.wdata;
              if (cur_q.wdata[eep_pkg::CMD_SUB_BIT]) begin
                if (opcode == eep_pkg::OPCODE_EXTENDED) begin
                  unique case (sub)
                    eep_pkg::SUB_WRITE_DISABLE: wen_q <= 1'b0;
                    eep_pkg::SUB_WRITE_ENABLE:  wen_q <= 1'b1;
                    eep_pkg::SUB_ERASE_ALL:     cnt_q <= '0;
                    eep_pkg::SUB_WRITE_ALL: begin
                    end
                  endcase
                end
              end else if (cur_q.wdata[eep_pkg::CMD_WRITE_BIT] ||
                           cur_q.wdata[eep_pkg::CMD_READ_BIT]) begin
                sel_addr_q <= cmd_addr;
              end
            end
            default: begin
            end
          endcase
        end
        ST_READ: begin
          out_valid_q <= 1'b1;
          out_data_q  <= ram_rdata;
          state_q     <= ST_IDLE;
        end
        ST_ERASE: begin
          cnt_q <= cnt_q + AW'(1);
          if (cnt_q == erase_last) begin
            state_q <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ----- hdl/internal_eeprom_port_controller.sv -----
// Top level of the internal EEPROM port controller.
// Each transfer on req_i is one bus access: op selects read or write, reg_sel picks
// the data low, data high, address low, address high or command/status port.
// Every access returns exactly one byte on rsp_o, in order; writes return zero.
// The color mode register is written through cfg_we_i and cfg_wdata_i; the user
// must write it only while idle, which the block does not enforce. Accesses enter
// a two-entry queue, so req_i keeps taking transfers while a result waits on rsp_o.
// The execution unit handles one access at a time; data port reads pass through a
// read state that waits on the registered read port of the store. A new access
// starts only once the last result has left rsp_o. After reset the store is
// cleared in one pass of one byte per cycle, all 1024 bytes at the default sizes;
// queued accesses wait until it completes. An erase-all command clears the bytes
// of the current mode the same way and blocks following accesses until it ends.
// When rsp_o stalls, the result holds and the queue fills; req_i deasserts ready
// once both queue entries are taken.
module internal_eeprom_port_controller #(
  parameter int unsigned COLOR_STORE_BYTES = 1024,
  parameter int unsigned MONO_STORE_BYTES  = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  eep_req_if.sink    req_i,
  eep_rsp_if.source  rsp_o
);

  eep_pkg::queue_head_t head;
  logic                 pop;

  eep_front u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_i),
    .pop_i (pop),
    .head_o(head)
  );

  eep_back #(
    .COLOR_STORE_BYTES(COLOR_STORE_BYTES),
    .MONO_STORE_BYTES (MONO_STORE_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .head_i     (head),
    .pop_o      (pop),
    .rsp_o      (rsp_o)
  );

`ifndef SYNTHESIS
  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid)
    else $error("Queue popped while empty.");

  a_pop_needs_free_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !rsp_o.valid)
    else $error("Access started while a result was still pending.");

  a_pop_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> !pop)
    else $error("Two accesses started in consecutive cycles.");

  a_no_refill_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.ready) |=> !rsp_o.valid)
    else $error("Result register refilled in the cycle after a transfer.");
`endif

endmodule
